>>> rtl/tccw_pkg.sv
package tccw_pkg;

    // default screen geometry
    localparam int DEF_COLUMNS  = 80;
    localparam int DEF_ROWS     = 25;
    localparam int DEF_TAB_STOP = 8;

    // cell and port widths
    localparam int CELL_W = 16;
    localparam int POS_W  = 11;

    // attribute after reset: white on black
    localparam logic [7:0] ATTR_RESET = 8'h0F;

    // item modes
    localparam logic [1:0] MODE_PUT   = 2'd0;
    localparam logic [1:0] MODE_CLEAR = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    // character codes
    localparam logic [7:0] CH_BACKSPACE  = 8'h08;
    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_LF         = 8'h0A;
    localparam logic [7:0] CH_CR         = 8'h0D;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_LAST_PRINT = 8'h7F;

    // input beat
    typedef struct packed {
        logic [1:0]       mode;
        logic [7:0]       char_code;
        logic [POS_W-1:0] read_index;
    } in_beat_t;

    // result beat
    typedef struct packed {
        logic [POS_W-1:0]  cursor_position;
        logic [CELL_W-1:0] cell_value;
        logic              did_scroll;
    } out_beat_t;

    // outcome of one put, from the cursor unit to the sequencer
    typedef struct packed {
        logic write_cell;
        logic scroll;
    } cur_flags_t;

endpackage

>>> rtl/tccw_screen_ram.sv
module tccw_screen_ram
    import tccw_pkg::*;
#(
    parameter int DEPTH  = DEF_ROWS * DEF_COLUMNS,
    parameter int ADDR_W = $clog2(DEF_ROWS * DEF_COLUMNS)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [CELL_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [CELL_W-1:0] rdata
);

    logic [CELL_W-1:0] mem_array [DEPTH];
    logic [CELL_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_array[waddr] <= wdata;
        end
    end

    // registered read port, holds its data between reads
    always_ff @(posedge aclk) begin
        if (re) begin
            rd_data_reg <= mem_array[raddr];
        end
    end

    assign rdata = rd_data_reg;

endmodule

>>> rtl/tccw_cursor.sv
module tccw_cursor
    import tccw_pkg::*;
#(
    parameter int COLUMNS  = DEF_COLUMNS,
    parameter int ROWS     = DEF_ROWS,
    parameter int TAB_STOP = DEF_TAB_STOP
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        put_en,
    input  logic                        home_en,
    input  logic [7:0]                  char_code,
    output logic [$clog2(COLUMNS)-1:0]  col,
    output logic [$clog2(ROWS)-1:0]     row,
    output cur_flags_t                  flags
);

    localparam int CW   = $clog2(COLUMNS);
    localparam int RW   = $clog2(ROWS);
    localparam int RW1  = RW + 1;
    localparam int PW   = $clog2(TAB_STOP);
    localparam int TMPW = $clog2(COLUMNS + TAB_STOP);

    localparam logic [TMPW-1:0] COLS_T   = TMPW'(COLUMNS);
    localparam logic [TMPW-1:0] TS_T     = TMPW'(TAB_STOP);
    localparam logic [PW-1:0]   PH_LAST  = PW'(TAB_STOP - 1);
    localparam logic [RW1-1:0]  ROWS_T   = RW1'(ROWS);
    localparam logic [RW-1:0]   ROW_LAST = RW'(ROWS - 1);

    logic [CW-1:0]   col_reg,   col_next;
    logic [RW-1:0]   row_reg,   row_next;
    logic [PW-1:0]   phase_reg, phase_next;   // column modulo the tab stop

    logic [TMPW-1:0] col_tmp;
    logic [PW-1:0]   phase_tmp;
    logic            row_inc;
    logic [RW1-1:0]  row_tmp;
    logic            printable;
    logic            scroll;

    // cursor move for the current character
    always_comb begin
        col_tmp   = TMPW'(col_reg);
        phase_tmp = phase_reg;
        row_inc   = 1'b0;
        printable = (char_code >= CH_SPACE) && (char_code <= CH_LAST_PRINT);

        priority if (char_code == CH_BACKSPACE) begin
            if (col_reg != '0) begin
                col_tmp   = TMPW'(col_reg) - TMPW'(1);
                phase_tmp = (phase_reg == '0) ? PH_LAST : phase_reg - PW'(1);
            end
        end else if (char_code == CH_TAB) begin
            col_tmp   = TMPW'(col_reg) + TS_T - TMPW'(phase_reg);
            phase_tmp = '0;
        end else if (char_code == CH_CR) begin
            col_tmp   = '0;
            phase_tmp = '0;
        end else if (char_code == CH_LF) begin
            col_tmp   = '0;
            phase_tmp = '0;
            row_inc   = 1'b1;
        end else if (printable) begin
            col_tmp   = TMPW'(col_reg) + TMPW'(1);
            phase_tmp = (phase_reg == PH_LAST) ? '0 : phase_reg + PW'(1);
        end

        // wrap past the last column
        if (col_tmp >= COLS_T) begin
            col_tmp   = '0;
            phase_tmp = '0;
            row_inc   = 1'b1;
        end

        // past the last row the screen scrolls
        row_tmp = RW1'(row_reg) + RW1'(row_inc);
        scroll  = (row_tmp >= ROWS_T);
    end

    // next cursor state
    always_comb begin
        col_next   = col_reg;
        row_next   = row_reg;
        phase_next = phase_reg;
        if (home_en) begin
            col_next   = '0;
            row_next   = '0;
            phase_next = '0;
        end else if (put_en) begin
            col_next   = col_tmp[CW-1:0];
            row_next   = scroll ? ROW_LAST : row_tmp[RW-1:0];
            phase_next = phase_tmp;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg   <= '0;
            row_reg   <= '0;
            phase_reg <= '0;
        end else begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            phase_reg <= phase_next;
        end
    end

    assign col              = col_reg;
    assign row              = row_reg;
    assign flags.write_cell = printable;
    assign flags.scroll     = scroll;

endmodule

>>> rtl/text_console_cell_writer_unit.sv
// A put, read or unused-mode beat is executed in S_EXEC and its result is registered in S_DONE;
// a new beat can be taken in the cycle its predecessor's result is loaded.
// Clear walks the screen memory one cell a cycle.
// A put that scrolls copies (ROWS-1)*COLUMNS cells and blanks COLUMNS cells through the
// single write port. Reset (aresetn, synchronous, low) homes the cursor and sets the
// attribute to 0x0F; screen cells stay undefined until written.
module text_console_cell_writer_unit
    import tccw_pkg::*;
#(
    parameter int COLUMNS  = DEF_COLUMNS,
    parameter int ROWS     = DEF_ROWS,
    parameter int TAB_STOP = DEF_TAB_STOP
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  in_beat_t   s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output out_beat_t  m_data,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data
);

    localparam int CELLS      = ROWS * COLUMNS;
    localparam int ADDR_W     = $clog2(CELLS);
    localparam int CW         = $clog2(COLUMNS);
    localparam int RW         = $clog2(ROWS);
    localparam int COPY_COUNT = (ROWS - 1) * COLUMNS;

    localparam logic [ADDR_W-1:0] COPY_END  = ADDR_W'(COPY_COUNT);
    localparam logic [ADDR_W-1:0] CELL_LAST = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(COLUMNS);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_EXEC  = 6'b000010,
        S_COPY  = 6'b000100,
        S_BLANK = 6'b001000,
        S_CLEAR = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    in_beat_t          item_reg, item_next;
    logic              scroll_reg, scroll_next;
    logic [ADDR_W-1:0] rd_cnt_reg, rd_cnt_next;
    logic [ADDR_W-1:0] wr_cnt_reg, wr_cnt_next;
    logic              pend_reg, pend_next;
    logic [7:0]        attr_reg, attr_next;
    logic              m_valid_reg, m_valid_next;
    out_beat_t         m_data_reg, m_data_next;

    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [CELL_W-1:0] mem_wdata, mem_rdata;

    logic              put_en, home_en;
    logic [CW-1:0]     cur_col;
    logic [RW-1:0]     cur_row;
    cur_flags_t        cur_flags;

    logic [ADDR_W-1:0] cur_addr;
    logic              rd_in_range;
    logic              out_free;
    logic [CELL_W-1:0] blank_cell;

    tccw_screen_ram #(
        .DEPTH  (CELLS),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    tccw_cursor #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_STOP (TAB_STOP)
    ) u_cursor (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .put_en    (put_en),
        .home_en   (home_en),
        .char_code (item_reg.char_code),
        .col       (cur_col),
        .row       (cur_row),
        .flags     (cur_flags)
    );

    // linear cursor address and read range check
    assign cur_addr    = ADDR_W'(cur_row) * COLS_A + ADDR_W'(cur_col);
    assign rd_in_range = (int'(item_reg.read_index) < CELLS);
    assign out_free    = !m_valid_reg || m_ready;
    assign blank_cell  = {attr_reg, CH_SPACE};

    // attribute register
    always_comb begin
        attr_next = attr_reg;
        if (cfg_wr_en) begin
            attr_next = cfg_wr_data;
        end
    end

    // sequencer
    always_comb begin
        state_next   = state_reg;
        item_next    = item_reg;
        scroll_next  = scroll_reg;
        rd_cnt_next  = rd_cnt_reg;
        wr_cnt_next  = wr_cnt_reg;
        pend_next    = pend_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        s_ready      = 1'b0;
        put_en       = 1'b0;
        home_en      = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = '0;
        mem_wdata    = '0;
        mem_re       = 1'b0;
        mem_raddr    = '0;

        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    item_next   = s_data;
                    scroll_next = 1'b0;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (item_reg.mode)
                    MODE_PUT: begin
                        put_en = 1'b1;
                        if (cur_flags.write_cell) begin
                            mem_we    = 1'b1;
                            mem_waddr = cur_addr;
                            mem_wdata = {attr_reg, item_reg.char_code};
                        end
                        if (cur_flags.scroll) begin
                            scroll_next = 1'b1;
                            rd_cnt_next = '0;
                            wr_cnt_next = '0;
                            pend_next   = 1'b0;
                            state_next  = S_COPY;
                        end else begin
                            state_next = S_DONE;
                        end
                    end
                    MODE_CLEAR: begin
                        home_en     = 1'b1;
                        wr_cnt_next = '0;
                        state_next  = S_CLEAR;
                    end
                    MODE_READ: begin
                        if (rd_in_range) begin
                            mem_re    = 1'b1;
                            mem_raddr = ADDR_W'(item_reg.read_index);
                        end
                        state_next = S_DONE;
                    end
                    default: begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_COPY: begin
                // read one row ahead, write the cell that the previous read returned
                if (rd_cnt_reg != COPY_END) begin
                    mem_re      = 1'b1;
                    mem_raddr   = rd_cnt_reg + COLS_A;
                    rd_cnt_next = rd_cnt_reg + ADDR_W'(1);
                    pend_next   = 1'b1;
                end else begin
                    pend_next = 1'b0;
                end
                if (pend_reg) begin
                    mem_we      = 1'b1;
                    mem_waddr   = wr_cnt_reg;
                    mem_wdata   = mem_rdata;
                    wr_cnt_next = wr_cnt_reg + ADDR_W'(1);
                end
                if (rd_cnt_reg == COPY_END && !pend_reg) begin
                    wr_cnt_next = COPY_END;
                    state_next  = S_BLANK;
                end
            end
            S_BLANK, S_CLEAR: begin
                mem_we      = 1'b1;
                mem_waddr   = wr_cnt_reg;
                mem_wdata   = blank_cell;
                wr_cnt_next = wr_cnt_reg + ADDR_W'(1);
                if (wr_cnt_reg == CELL_LAST) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    m_valid_next                = 1'b1;
                    m_data_next.cursor_position = POS_W'(cur_addr);
                    m_data_next.cell_value      =
                        (item_reg.mode == MODE_READ && rd_in_range) ? mem_rdata : '0;
                    m_data_next.did_scroll      = scroll_reg;
                    s_ready                     = 1'b1;
                    if (s_valid) begin
                        item_next   = s_data;
                        scroll_next = 1'b0;
                        state_next  = S_EXEC;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            pend_reg    <= 1'b0;
            attr_reg    <= ATTR_RESET;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            pend_reg    <= pend_next;
            attr_reg    <= attr_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        item_reg   <= item_next;
        scroll_reg <= scroll_next;
        rd_cnt_reg <= rd_cnt_next;
        wr_cnt_reg <= wr_cnt_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
